### rtl/core/fce_pkg.sv
// Package for the fraction comparator: datapath command and status types.
package fce_pkg;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture operands
    logic div_go;   // start both serial divisions
    logic swap;     // replace p,q by q,rem and r,s by s,rem; flip sense
  } fce_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic bad;      // a denominator is zero
    logic div_done; // both divisions finished
    logic quo_ne;   // quotients differ
    logic quo_lt;   // left quotient below right quotient
    logic rem_l_z;  // left remainder zero
    logic rem_r_z;  // right remainder zero
    logic flipped;  // current comparison sense is inverted
  } fce_sts_t;

endpackage

### rtl/core/fce_datapath.sv
// Datapath: operand registers and two bit-serial restoring dividers.
module fce_datapath import fce_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] num_left,
  input  logic [WIDTH-1:0] den_left,
  input  logic [WIDTH-1:0] num_right,
  input  logic [WIDTH-1:0] den_right,
  input  fce_cmd_t         cmd,
  output fce_sts_t         sts
);
  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] q_l, q_r;           // denominators
  logic [WIDTH-1:0] quo_l, quo_r;       // dividend shifts into quotient
  logic [WIDTH:0]   rem_l, rem_r;       // partial remainders
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             flipped;

  logic [WIDTH:0] sh_l, sh_r, df_l, df_r;

  // One restoring step per cycle for each side
  always_comb begin
    sh_l = {rem_l[WIDTH-1:0], quo_l[WIDTH-1]};
    sh_r = {rem_r[WIDTH-1:0], quo_r[WIDTH-1]};
    df_l = sh_l - {1'b0, q_l};
    df_r = sh_r - {1'b0, q_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_l   <= num_left;
      q_l     <= den_left;
      quo_r   <= num_right;
      q_r     <= den_right;
      flipped <= 1'b0;
      busy    <= 1'b0;
    end else if (cmd.div_go) begin
      rem_l <= '0;
      rem_r <= '0;
      cnt   <= CW'(WIDTH);
      busy  <= 1'b1;
    end else if (cmd.swap) begin
      // next round divides old denominator by the remainder
      quo_l   <= q_l;
      quo_r   <= q_r;
      q_l     <= rem_l[WIDTH-1:0];
      q_r     <= rem_r[WIDTH-1:0];
      flipped <= ~flipped;
    end else if (busy) begin
      rem_l <= df_l[WIDTH] ? sh_l : df_l;
      rem_r <= df_r[WIDTH] ? sh_r : df_r;
      quo_l <= {quo_l[WIDTH-2:0], ~df_l[WIDTH]};
      quo_r <= {quo_r[WIDTH-2:0], ~df_r[WIDTH]};
      cnt   <= cnt - CW'(1);
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  assign sts.bad      = (q_l == '0) || (q_r == '0);
  assign sts.div_done = ~busy;
  assign sts.quo_ne   = quo_l != quo_r;
  assign sts.quo_lt   = quo_l < quo_r;
  assign sts.rem_l_z  = rem_l == '0;
  assign sts.rem_r_z  = rem_r == '0;
  assign sts.flipped  = flipped;
endmodule

### rtl/core/fce_ctrl.sv
// Controller: sequences the Euclid rounds and holds the result register.
module fce_ctrl import fce_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output logic     is_less,
  output logic     is_equal,
  output logic     bad_operand,
  output fce_cmd_t cmd,
  input  fce_sts_t sts
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_START = 5'b00100,
    S_DIV   = 5'b01000,
    S_EVAL  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   res_load, res_less, res_eq, res_bad;

  // Accept a new request only when idle and the result slot is free
  assign in_stall = !(state == S_IDLE) || out_valid;

  always_comb begin
    state_next = state;
    cmd        = '0;
    res_load   = 1'b0;
    res_less   = 1'b0;
    res_eq     = 1'b0;
    res_bad    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.bad) begin
          res_load   = 1'b1;
          res_bad    = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.div_go = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_EVAL;
      end
      S_EVAL: begin
        // quotients differ, or a remainder ends the walk
        if (sts.quo_ne) begin
          res_load   = 1'b1;
          res_less   = sts.quo_lt ^ sts.flipped;
          state_next = S_IDLE;
        end else if (sts.rem_l_z || sts.rem_r_z) begin
          res_load   = 1'b1;
          res_eq     = sts.rem_l_z && sts.rem_r_z;
          res_less   = !res_eq && (sts.rem_l_z ^ sts.flipped);
          state_next = S_IDLE;
        end else begin
          cmd.swap   = 1'b1;
          state_next = S_START;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      is_less     <= res_less;
      is_equal    <= res_eq;
      bad_operand <= res_bad;
    end
  end
endmodule

### rtl/core/fraction_compare_euclid.sv
// Exact comparison of two nonnegative fractions by continued-fraction walk.
// One request at a time. After a request is taken, the check state tests the
// denominators; then each Euclid round runs through start, WIDTH restoring
// steps (one serial divider per fraction, both in step), done and evaluate.
// A walk takes up to about 93 rounds for 64-bit operands in the worst case; on
// a zero denominator the result is loaded straight from the check, with no rounds.
// Operand bits above WIDTH are ignored. The result stays until taken and a
// new request waits for it, so no request is taken while a result is pending.
module fraction_compare_euclid import fce_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] num_left,
  input  logic [63:0] den_left,
  input  logic [63:0] num_right,
  input  logic [63:0] den_right,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_less,
  output logic        is_equal,
  output logic        bad_operand
);
  fce_cmd_t cmd;
  fce_sts_t sts;

  fce_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk(clk),
    .num_left(num_left[WIDTH-1:0]),
    .den_left(den_left[WIDTH-1:0]),
    .num_right(num_right[WIDTH-1:0]),
    .den_right(den_right[WIDTH-1:0]),
    .cmd(cmd),
    .sts(sts)
  );

  fce_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .is_less(is_less), .is_equal(is_equal), .bad_operand(bad_operand),
    .cmd(cmd), .sts(sts)
  );
endmodule

### rtl/core/fce_checker.sv
// Port checker for the fraction comparator, bound to the top level.
module fce_port_checks (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic is_less,
  input logic is_equal,
  input logic bad_operand
);
  // result flags are mutually exclusive
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({is_less, is_equal, bad_operand}) <= 1)
    else $error("result flags overlap");

  // no request taken while a result waits
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request accepted with result pending");

  // an accepted request cannot produce a result on the next edge
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("result too early");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable({is_less, is_equal, bad_operand}))
    else $error("stalled result changed");
endmodule

bind fraction_compare_euclid fce_port_checks u_chk (.*);
